// ===== hw/rtl/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants for the sorted list table
// Command codes, status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_ERRO = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_INS_SHIFT,
    S_DEL_SHIFT,
    S_DONE
  } slt_state_t;

endpackage

// ===== hw/rtl/sorted_list_table.sv =====
// ----------------------------------------------------------------------------
// sorted_list_table: bounded ascending multiset of signed 32-bit keys
// The scan reads one entry per cycle and a shift picks up at the hit, so insert,
// delete and a lookup miss all pass over every stored key before the result.
// Full insert or unused command: out_tvalid rises in the cycle after the input
// transfer. One item at a time: the next is taken once the result is accepted.
// Reset empties the table at once (count cleared).
// ----------------------------------------------------------------------------
module sorted_list_table
  import slt_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tuser,   // [1:0] command
  input  logic [31:0] in_tdata,   // [31:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [0] status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [31:0]   mem [CAPACITY];
  logic [31:0]   rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;

  slt_state_t    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;     // address issued this cycle
  logic          rd_vld_r, rd_vld_nxt; // rd_data_r holds entry idx_r-1
  logic [1:0]    cmd_r, cmd_nxt;
  logic [31:0]   key_r, key_nxt;
  logic [31:0]   carry_r, carry_nxt; // insert: key moving up one slot
  logic          status_r, status_nxt;
  logic [CW-1:0] pos_r, pos_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
    idx_r    <= idx_nxt;
    cmd_r    <= cmd_nxt;
    key_r    <= key_nxt;
    carry_r  <= carry_nxt;
    status_r <= status_nxt;
    pos_r    <= pos_nxt;
  end

  logic          rd_le;  // key <= read entry (signed)
  logic          rd_eq;
  logic [CW-1:0] prev;
  assign rd_le = $signed(key_r) <= $signed(rd_data_r);
  assign rd_eq = key_r == rd_data_r;
  assign prev  = idx_r - CW'(1);

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = state_r == S_DONE;
  assign out_tdata  = {7'd0, status_r};

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    rd_vld_nxt = 1'b0;
    cmd_nxt    = cmd_r;
    key_nxt    = key_r;
    carry_nxt  = carry_r;
    status_nxt = status_r;
    pos_nxt    = pos_r;
    rd_addr    = idx_r[AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = idx_r[AW-1:0];
    wr_data    = key_r;
    unique case (state_r)
      S_IDLE: begin
        rd_addr = '0;
        if (in_tvalid) begin
          cmd_nxt = in_tuser[1:0];
          key_nxt = in_tdata;
          idx_nxt = '0;
          if (in_tuser[1:0] == CMD_INSERT && count_r == CAP_C) begin
            status_nxt = ST_ERRO;
            state_nxt  = S_DONE;
          end else if (in_tuser[1:0] != CMD_INSERT && in_tuser[1:0] != CMD_DELETE &&
                       in_tuser[1:0] != CMD_LOOKUP) begin
            status_nxt = ST_ERRO;
            state_nxt  = S_DONE;
          end else begin
            // address 0 is issued now; data valid next cycle
            idx_nxt    = CW'(1);
            rd_vld_nxt = count_r != '0;
            state_nxt  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // rd_data_r holds entry idx_r-1 when rd_vld_r
        if (!rd_vld_r) begin
          // ran past the end without a hit
          if (cmd_r == CMD_INSERT) begin
            wr_en      = 1'b1;
            wr_addr    = count_r[AW-1:0];
            wr_data    = key_r;
            count_nxt  = count_r + CW'(1);
            status_nxt = ST_OK;
          end else begin
            status_nxt = ST_ERRO;
          end
          state_nxt = S_DONE;
        end else if (cmd_r == CMD_INSERT && rd_le) begin
          // place key at prev, carry old entry upward
          wr_en     = 1'b1;
          wr_addr   = prev[AW-1:0];
          wr_data   = key_r;
          carry_nxt = rd_data_r;
          rd_vld_nxt = idx_r < count_r;
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_INS_SHIFT;
        end else if (cmd_r != CMD_INSERT && rd_eq) begin
          if (cmd_r == CMD_LOOKUP) begin
            status_nxt = ST_OK;
            state_nxt  = S_DONE;
          end else begin
            pos_nxt    = prev;
            rd_vld_nxt = idx_r < count_r;
            idx_nxt    = idx_r + CW'(1);
            state_nxt  = S_DEL_SHIFT;
          end
        end else begin
          rd_vld_nxt = idx_r < count_r;
          idx_nxt    = idx_r + CW'(1);
        end
      end
      S_INS_SHIFT: begin
        // carried entry moves to slot idx_r-1
        wr_en   = 1'b1;
        wr_addr = prev[AW-1:0];
        wr_data = carry_r;
        if (rd_vld_r) begin
          carry_nxt  = rd_data_r;
          rd_vld_nxt = idx_r < count_r;
          idx_nxt    = idx_r + CW'(1);
        end else begin
          count_nxt  = count_r + CW'(1);
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
        end
      end
      S_DEL_SHIFT: begin
        if (rd_vld_r) begin
          wr_en      = 1'b1;
          wr_addr    = pos_r[AW-1:0];
          wr_data    = rd_data_r;
          pos_nxt    = pos_r + CW'(1);
          rd_vld_nxt = idx_r < count_r;
          idx_nxt    = idx_r + CW'(1);
        end else begin
          count_nxt  = count_r - CW'(1);
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // In insert shift, entry idx_r-1 was read the cycle before; the write goes to
  // the same slot in this cycle, after the read, so no overlap arises.

  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CAP_C)
    else $error("count exceeds capacity");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |=> in_tready)
    else $error("not idle after result transfer");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |=> $stable(count_r))
    else $error("count changed while idle");

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: sorted list table testbench
// Directed and random command/key stream against a behavioral sorted multiset, with bursty
// input and a stalling result side. Each status is checked in order.
// ----------------------------------------------------------------------------
module tb_top
  import slt_pkg::*;
();

  localparam int CAP       = 64;
  localparam int N_RANDOM  = 460;
  localparam int WDOG_MAX  = 5000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] key;
  } slt_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tuser = '0;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;

  // accepted-input flag sampled at the rising edge
  logic        in_tready_seen = 1'b0;

  sorted_list_table #(.CAPACITY(CAP)) DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  slt_item_t     pending_q[$];
  logic          status_q[$];
  logic [31:0]   keys[$];     // ascending signed model of the table
  int            errors = 0;
  int            wdog = 0;
  bit            stim_done = 0;
  bit            hold_off = 0;
  int            burst_left = 0;
  int            gap_left = 0;
  int            stall_phase = 0;

  task automatic report(input string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  function automatic logic predict_status(input slt_item_t it);
    int pos;
    pos = 0;
    case (it.cmd)
      CMD_INSERT: begin
        if (keys.size() >= CAP) return ST_ERRO;
        while (pos < keys.size() && $signed(it.key) > $signed(keys[pos])) pos++;
        keys.insert(pos, it.key);
        return ST_OK;
      end
      CMD_DELETE: begin
        for (int i = 0; i < keys.size(); i++)
          if (keys[i] == it.key) begin
            keys.delete(i);
            return ST_OK;
          end
        return ST_ERRO;
      end
      CMD_LOOKUP: begin
        foreach (keys[i]) if (keys[i] == it.key) return ST_OK;
        return ST_ERRO;
      end
      default: return ST_ERRO;
    endcase
  endfunction

  function automatic slt_item_t mk(input logic [1:0] c, input logic [31:0] k);
    slt_item_t it;
    it.cmd = c;
    it.key = k;
    return it;
  endfunction

  // small key pool gives hits and duplicates; occasional full-range keys
  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'h7fff_fffc + $urandom_range(0, 3);
      default: return $urandom_range(0, 15) - 8;
    endcase
  endfunction

  // driver
  always @(negedge clk) begin
    slt_item_t it;
    logic vld;
    if (rst_n) begin
      // keep an item that has not been transferred yet
      vld = in_tvalid && !in_tready_seen;
      if (!vld) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0 && !(hold_off && status_q.size() > 0)) begin
          it = pending_q.pop_front();
          in_tuser <= {6'b0, it.cmd};
          in_tdata <= it.key;
          vld = 1'b1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      in_tvalid <= vld;
      stall_phase = (stall_phase + 1) % 23;
      out_tready <= (stall_phase < 8) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    slt_item_t it;
    logic exp_st;
    in_tready_seen <= in_tvalid && in_tready;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) wdog <= 0;
      else wdog <= wdog + 1;
      if (in_tvalid && in_tready) begin
        it.cmd = in_tuser[1:0];
        it.key = in_tdata;
        status_q.push_back(predict_status(it));
      end
      if (out_tvalid && out_tready) begin
        if (status_q.size() == 0) report("status with no command pending");
        else begin
          exp_st = status_q.pop_front();
          if (out_tdata[0] !== exp_st)
            report($sformatf("status got %b expected %b", out_tdata[0], exp_st));
        end
      end
      if (wdog >= WDOG_MAX) begin
        $display("watchdog expired");
        $display("sorted_list_table test failed");
        $finish;
      end
    end
  end

  initial begin
    logic [1:0] c;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // directed: empty-table errors, extremes, duplicates, unused code
    pending_q.push_back(mk(CMD_DELETE, 32'd5));
    pending_q.push_back(mk(CMD_LOOKUP, 32'd5));
    pending_q.push_back(mk(CMD_INSERT, 32'h7fff_ffff));
    pending_q.push_back(mk(CMD_INSERT, 32'h8000_0000));
    pending_q.push_back(mk(CMD_INSERT, 32'h0000_0000));
    pending_q.push_back(mk(CMD_INSERT, 32'hffff_ffff));
    pending_q.push_back(mk(CMD_INSERT, 32'h0000_0000));
    pending_q.push_back(mk(CMD_LOOKUP, 32'h8000_0000));
    pending_q.push_back(mk(CMD_LOOKUP, 32'h7fff_ffff));
    pending_q.push_back(mk(CMD_LOOKUP, 32'h1234_5678));
    pending_q.push_back(mk(CMD_DELETE, 32'h0000_0000));
    pending_q.push_back(mk(CMD_LOOKUP, 32'h0000_0000));
    pending_q.push_back(mk(CMD_DELETE, 32'h0000_0000));
    pending_q.push_back(mk(CMD_DELETE, 32'h0000_0000));
    pending_q.push_back(mk(2'd3, 32'hffff_ffff));
    pending_q.push_back(mk(CMD_DELETE, 32'h8000_0000));
    pending_q.push_back(mk(CMD_DELETE, 32'h7fff_ffff));
    pending_q.push_back(mk(CMD_DELETE, 32'hffff_ffff));
    // fill past capacity, then probe the full table
    for (int i = 0; i < CAP + 3; i++) pending_q.push_back(mk(CMD_INSERT, rand_key()));
    pending_q.push_back(mk(CMD_LOOKUP, 32'h8000_0000));
    for (int i = 0; i < 150; i++) begin
      c = $urandom_range(0, 9) < 3 ? CMD_INSERT : ($urandom_range(0, 9) < 7 ? CMD_DELETE
                                                   : CMD_LOOKUP);
      if ($urandom_range(0, 40) == 0) c = 2'd3;
      pending_q.push_back(mk(c, rand_key()));
    end
    while (pending_q.size() > 0) @(posedge clk);
    // drain fully before continuing
    hold_off = 1;
    for (int i = 0; i < N_RANDOM - 150; i++) begin
      c = 2'($urandom_range(0, 2));
      if ($urandom_range(0, 40) == 0) c = 2'd3;
      pending_q.push_back(mk(c, rand_key()));
    end
    @(posedge clk);
    while (status_q.size() > 0) @(posedge clk);
    hold_off = 0;
    while (pending_q.size() > 0 || in_tvalid) @(posedge clk);
    while (status_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && status_q.size() == 0) $display("sorted_list_table test passed");
    else $display("sorted_list_table test failed");
    $finish;
  end

endmodule

// ===== sorted_list_table.f =====
hw/rtl/slt_pkg.sv
hw/rtl/sorted_list_table.sv
sim/tb_top.sv
